// ===== hw/rtl/bcts_pkg.sv =====
// Shared types and constants for the battery cycle test sequencer.
`default_nettype none

package bcts_pkg;

    // Field widths.
    localparam int unsigned StepW = 4;
    localparam int unsigned BatW  = 13;
    localparam int unsigned SolW  = 15;
    localparam int unsigned TimeW = 32;
    localparam int unsigned CfgIdxW  = 2;
    localparam int unsigned CfgDataW = 13;

    // Timing and voltage thresholds.
    localparam logic [TimeW-1:0] ReportPeriodMs = 32'd2000;
    localparam logic [TimeW-1:0] AbsorbPeriodMs = 32'd10800000;
    localparam logic [BatW-1:0]  FirstReportMv  = 13'd6550;
    localparam logic [BatW-1:0]  ReportStepMv   = 13'd50;
    localparam logic [BatW-1:0]  BatteryFloorMv = 13'd4000;
    localparam logic [SolW-1:0]  SolarDayMv     = 15'd18000;
    localparam logic [SolW-1:0]  MpptLowMv      = 15'd16000;
    localparam logic [SolW-1:0]  MpptHighMv     = 15'd17000;
    localparam logic [SolW-1:0]  NightHighMv    = 15'd5000;

    // Configuration register reset values.
    localparam logic [StepW-1:0] StartStepRst   = 4'd0;
    localparam logic [StepW-1:0] EndStepRst     = 4'd15;
    localparam logic [BatW-1:0]  DischargeMvRst = 13'd6200;

    // Configuration register indexes.
    typedef enum logic [CfgIdxW-1:0] {
        REG_START_STEP   = 2'd0,
        REG_END_STEP     = 2'd1,
        REG_DISCHARGE_MV = 2'd2,
        REG_RUN_MODE     = 2'd3
    } cfg_reg_t;

    // Sequencer phases.
    typedef enum logic [2:0] {
        PH_IDLE   = 3'd0,
        PH_CHECK  = 3'd1,
        PH_MPPT   = 3'd2,
        PH_DELAY  = 3'd3,
        PH_ABSORB = 3'd4,
        PH_NIGHT  = 3'd5
    } phase_t;

    // Event codes reported with each result.
    typedef enum logic [2:0] {
        EV_NONE    = 3'd0,
        EV_REPORT  = 3'd1,
        EV_ABS_BEG = 3'd2,
        EV_ABS_END = 3'd3,
        EV_MPPT    = 3'd4,
        EV_NIGHT   = 3'd5
    } event_t;

endpackage

`default_nettype wire

// ===== hw/rtl/battery_cycle_test_sequencer.sv =====
// A result appears in the output register in the cycle after its poll is accepted.
// Throughput: one poll per cycle while the result side does not stall; the single result register is the only stage.
// A poll is taken whenever the result register is empty or its result leaves the same cycle.
// Reset puts the sequencer in idle with load 0 and charger enabled, and restores the
// configuration registers to start step 0, end step 15, setpoint 6200 mV and sweep mode.
`default_nettype none

module battery_cycle_test_sequencer (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    // Configuration write channel.
    input  wire logic                         cfg_valid,
    output logic                              cfg_ready,
    input  wire logic [bcts_pkg::CfgIdxW-1:0] cfg_index,
    input  wire logic [bcts_pkg::CfgDataW-1:0] cfg_data,
    // Poll request channel.
    input  wire logic                         in_valid,
    output logic                              in_stall,
    input  wire logic                         start_req,
    input  wire logic [bcts_pkg::TimeW-1:0]   now_ms,
    input  wire logic [bcts_pkg::BatW-1:0]    battery_mv,
    input  wire logic [bcts_pkg::SolW-1:0]    solar_mv,
    // Result channel.
    output logic                              out_valid,
    input  wire logic                         out_stall,
    output logic [bcts_pkg::StepW-1:0]        load_level,
    output logic                              charger_off,
    output logic [2:0]                        event_res
);
    import bcts_pkg::*;

    // Configuration registers.
    logic [StepW-1:0] start_step_reg;
    logic [StepW-1:0] end_step_reg;
    logic [BatW-1:0]  discharge_mv_reg;
    logic             run_mode_reg;

    // Sequencer state.
    phase_t           phase_reg, phase_next;
    logic [StepW-1:0] load_now_reg, load_now_next;
    logic             charger_shut_reg, charger_shut_next;
    logic             steady_run_reg, steady_run_next;
    logic             absorbing_reg, absorbing_next;
    logic [BatW-1:0]  report_level_reg, report_level_next;
    logic [TimeW-1:0] report_start_reg, report_start_next;
    logic [TimeW-1:0] absorb_start_reg, absorb_start_next;
    logic [StepW-1:0] lat_start_reg, lat_start_next;
    logic [StepW-1:0] lat_end_reg, lat_end_next;
    logic [BatW-1:0]  lat_setpoint_reg, lat_setpoint_next;
    logic             lat_fixed_reg, lat_fixed_next;

    // Result register.
    logic             out_valid_reg;
    logic [StepW-1:0] load_level_reg;
    logic             charger_off_reg;
    event_t           event_reg, event_next;

    logic in_accept;
    logic out_accept;

    // Decision terms shared by the phase and datapath logic.
    logic             at_top;
    logic             bat_ok;
    logic             below_set;
    logic             below_report;
    logic             sun_up;
    logic             first_step;
    logic             mppt_win;
    logic             night_win;
    logic [TimeW-1:0] report_elapsed;
    logic [TimeW-1:0] absorb_elapsed;
    logic             report_due;
    logic             absorb_due;

    // Handshakes: the result register frees up in the same cycle it is taken.
    assign cfg_ready  = 1'b1;
    assign in_stall   = out_valid_reg & out_stall;
    assign in_accept  = in_valid & ~in_stall;
    assign out_accept = out_valid_reg & ~out_stall;

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_step_reg   <= StartStepRst;
            end_step_reg     <= EndStepRst;
            discharge_mv_reg <= DischargeMvRst;
            run_mode_reg     <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_START_STEP:   start_step_reg   <= cfg_data[StepW-1:0];
                REG_END_STEP:     end_step_reg     <= cfg_data[StepW-1:0];
                REG_DISCHARGE_MV: discharge_mv_reg <= cfg_data[BatW-1:0];
                REG_RUN_MODE:     run_mode_reg     <= cfg_data[0];
                default:          run_mode_reg     <= run_mode_reg;
            endcase
        end
    end

    // Comparisons against thresholds and elapsed times (modulo 2^32).
    assign at_top         = load_now_reg >= lat_end_reg;
    assign bat_ok         = battery_mv > BatteryFloorMv;
    assign below_set      = battery_mv < lat_setpoint_reg;
    assign below_report   = battery_mv < report_level_reg;
    assign sun_up         = solar_mv > SolarDayMv;
    assign first_step     = (load_now_reg == lat_start_reg) && !charger_shut_reg
                            && !steady_run_reg;
    assign mppt_win       = (solar_mv > MpptLowMv) && (solar_mv < MpptHighMv);
    assign night_win      = (solar_mv != '0) && (solar_mv < NightHighMv);
    assign report_elapsed = now_ms - report_start_reg;
    assign absorb_elapsed = now_ms - absorb_start_reg;
    assign report_due     = report_elapsed > ReportPeriodMs;
    assign absorb_due     = absorb_elapsed > AbsorbPeriodMs;

    // Next phase.
    always_comb
    begin
        phase_next = phase_reg;
        if (start_req)
        begin
            phase_next = PH_CHECK;
        end
        else
        begin
            case (phase_reg)
                PH_CHECK:
                begin
                    if (absorbing_reg)
                    begin
                        phase_next = PH_ABSORB;
                    end
                    else if (at_top)
                    begin
                        if (below_set && bat_ok)
                        begin
                            phase_next = PH_MPPT;
                        end
                        else if (below_report && bat_ok)
                        begin
                            phase_next = PH_DELAY;
                        end
                    end
                    else if (lat_fixed_reg)
                    begin
                        phase_next = PH_DELAY;
                    end
                    else if (sun_up && !first_step)
                    begin
                        phase_next = steady_run_reg ? PH_ABSORB : PH_DELAY;
                    end
                end
                PH_MPPT:
                begin
                    if (lat_fixed_reg || mppt_win)
                    begin
                        phase_next = PH_DELAY;
                    end
                end
                PH_DELAY:
                begin
                    if (report_due)
                    begin
                        phase_next = PH_CHECK;
                    end
                end
                PH_ABSORB:
                begin
                    if (absorb_due)
                    begin
                        phase_next = PH_NIGHT;
                    end
                end
                PH_NIGHT:
                begin
                    if (lat_fixed_reg || night_win)
                    begin
                        phase_next = PH_DELAY;
                    end
                end
                default:
                begin
                    phase_next = PH_IDLE;
                end
            endcase
        end
    end

    // Datapath updates and event code for the current poll.
    always_comb
    begin
        load_now_next     = load_now_reg;
        charger_shut_next = charger_shut_reg;
        steady_run_next   = steady_run_reg;
        absorbing_next    = absorbing_reg;
        report_level_next = report_level_reg;
        report_start_next = report_start_reg;
        absorb_start_next = absorb_start_reg;
        lat_start_next    = lat_start_reg;
        lat_end_next      = lat_end_reg;
        lat_setpoint_next = lat_setpoint_reg;
        lat_fixed_next    = lat_fixed_reg;
        event_next        = EV_NONE;
        if (start_req)
        begin
            // A start request latches the run settings from the registers.
            lat_fixed_next    = run_mode_reg;
            lat_start_next    = start_step_reg;
            lat_end_next      = run_mode_reg ? start_step_reg : end_step_reg;
            lat_setpoint_next = discharge_mv_reg;
            load_now_next     = start_step_reg;
            steady_run_next   = run_mode_reg;
            absorbing_next    = 1'b0;
            if (run_mode_reg)
            begin
                charger_shut_next = 1'b1;
            end
            report_start_next = now_ms;
            event_next        = EV_REPORT;
        end
        else
        begin
            case (phase_reg)
                PH_CHECK:
                begin
                    if (absorbing_reg)
                    begin
                        event_next = EV_NONE;
                    end
                    else if (at_top)
                    begin
                        // At the top step, watch the battery discharge.
                        if (below_set && bat_ok)
                        begin
                            load_now_next     = lat_start_reg;
                            steady_run_next   = 1'b1;
                            charger_shut_next = 1'b0;
                        end
                        else if (below_report && bat_ok)
                        begin
                            report_level_next = (report_level_reg >= ReportStepMv)
                                                ? report_level_reg - ReportStepMv : '0;
                        end
                    end
                    else if (!lat_fixed_reg && sun_up)
                    begin
                        // Sweep the load up while the sun is strong; in a steady run, begin absorption.
                        if (first_step)
                        begin
                            charger_shut_next = 1'b1;
                            report_level_next = FirstReportMv;
                        end
                        else if (!steady_run_reg)
                        begin
                            load_now_next = load_now_reg + StepW'(1);
                        end
                        else
                        begin
                            absorb_start_next = now_ms;
                            absorbing_next    = 1'b1;
                            event_next        = EV_ABS_BEG;
                        end
                    end
                end
                PH_MPPT:
                begin
                    if (!lat_fixed_reg && mppt_win)
                    begin
                        event_next = EV_MPPT;
                    end
                end
                PH_DELAY:
                begin
                    if (report_due)
                    begin
                        report_start_next = now_ms;
                        event_next        = EV_REPORT;
                    end
                end
                PH_ABSORB:
                begin
                    if (absorb_due)
                    begin
                        absorbing_next = 1'b0;
                        event_next     = EV_ABS_END;
                    end
                end
                PH_NIGHT:
                begin
                    // Night reached: load the battery at the top step again.
                    if (!lat_fixed_reg && night_win)
                    begin
                        load_now_next     = lat_end_reg;
                        charger_shut_next = 1'b1;
                        report_level_next = FirstReportMv;
                        event_next        = EV_NIGHT;
                    end
                end
                default:
                begin
                    event_next = EV_NONE;
                end
            endcase
        end
    end

    // Sequencer state registers, updated on each accepted poll.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_IDLE;
            load_now_reg     <= '0;
            charger_shut_reg <= 1'b0;
            steady_run_reg   <= 1'b0;
            absorbing_reg    <= 1'b0;
            report_level_reg <= '0;
            report_start_reg <= '0;
            absorb_start_reg <= '0;
            lat_start_reg    <= '0;
            lat_end_reg      <= '0;
            lat_setpoint_reg <= '0;
            lat_fixed_reg    <= 1'b0;
        end
        else if (in_accept)
        begin
            phase_reg        <= phase_next;
            load_now_reg     <= load_now_next;
            charger_shut_reg <= charger_shut_next;
            steady_run_reg   <= steady_run_next;
            absorbing_reg    <= absorbing_next;
            report_level_reg <= report_level_next;
            report_start_reg <= report_start_next;
            absorb_start_reg <= absorb_start_next;
            lat_start_reg    <= lat_start_next;
            lat_end_reg      <= lat_end_next;
            lat_setpoint_reg <= lat_setpoint_next;
            lat_fixed_reg    <= lat_fixed_next;
        end
    end

    // Result valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_accept)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Result payload.
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            load_level_reg  <= load_now_next;
            charger_off_reg <= charger_shut_next;
            event_reg       <= event_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign load_level  = load_level_reg;
    assign charger_off = charger_off_reg;
    assign event_res   = event_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/bcts_checker.sv =====
// Port-level assertions for the battery cycle test sequencer, bound to the top level.
`default_nettype none

module bcts_checker (
    input wire logic                         clk,
    input wire logic                         rst_n,
    input wire logic                         in_valid,
    input wire logic                         in_stall,
    input wire logic                         start_req,
    input wire logic                         out_valid,
    input wire logic                         out_stall,
    input wire logic [bcts_pkg::StepW-1:0]   load_level,
    input wire logic                         charger_off,
    input wire logic [2:0]                   event_res
);
    import bcts_pkg::*;

    // Every accepted poll leaves a result in the output register.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> out_valid)
    else $error("accepted request produced no result");

    // A start request always answers with a report event.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && start_req) |=> (event_res == EV_REPORT))
    else $error("start request did not report");

    // A stalled result holds its payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(load_level)
            && $stable(charger_off) && $stable(event_res)))
    else $error("stalled result changed");

    // Night detection always shuts the charger again.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (event_res == EV_NIGHT)) |-> charger_off)
    else $error("night event with charger enabled");

    // Event codes stay within the defined set.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (event_res <= EV_NIGHT))
    else $error("undefined event code");

endmodule

bind battery_cycle_test_sequencer bcts_checker u_bcts_checker (.*);

`default_nettype wire

// ===== bench/tb_battery_cycle_test_sequencer.sv =====
// Self-checking testbench for the battery cycle test sequencer, with a cycle-level predictor.
`default_nettype none

module tb_battery_cycle_test_sequencer;
    import bcts_pkg::*;

    localparam int RandPolls = 700;
    localparam int CalmPolls = 100;
    localparam int RegPeriod = 120;

    typedef enum logic {
        ROW_POLL,
        ROW_CFG
    } row_kind_t;

    // One result as the block shows it.
    typedef struct packed {
        logic [StepW-1:0] load;
        logic             shut;
        event_t           ev;
    } step_result_t;

    // One line of the directed table: a poll request or a register set.
    typedef struct packed {
        row_kind_t        kind;
        logic             req;
        logic [TimeW-1:0] now;
        logic [BatW-1:0]  bat;
        logic [SolW-1:0]  sol;
        logic             typed;
        step_result_t     want;
        logic [StepW-1:0] c_start;
        logic [StepW-1:0] c_end;
        logic [BatW-1:0]  c_disch;
        logic             c_mode;
    } dir_row_t;

    logic                clk = 1'b0;
    logic                rst_n;
    logic                cfg_valid;
    logic                cfg_ready;
    logic [CfgIdxW-1:0]  cfg_index;
    logic [CfgDataW-1:0] cfg_data;
    logic                in_valid;
    logic                in_stall;
    logic                start_req;
    logic [TimeW-1:0]    now_ms;
    logic [BatW-1:0]     battery_mv;
    logic [SolW-1:0]     solar_mv;
    logic                out_valid;
    logic                out_stall;
    logic [StepW-1:0]    load_level;
    logic                charger_off;
    logic [2:0]          event_res;

    logic calm = 1'b0;
    int   fail_count = 0;

    step_result_t pending_results[$];

    // Register copies as the block holds them after reset.
    logic [StepW-1:0] start_reg = StartStepRst;
    logic [StepW-1:0] end_reg = EndStepRst;
    logic [BatW-1:0]  disch_reg = DischargeMvRst;
    logic             mode_reg = 1'b0;

    // Sequencer state mirrored by the predictor.
    phase_t           phase_q = PH_IDLE;
    logic [StepW-1:0] load_q = '0;
    logic             shut_q = 1'b0;
    logic             steady_q = 1'b0;
    logic             absorbing_q = 1'b0;
    logic [BatW-1:0]  level_q = '0;
    logic [TimeW-1:0] report_start_q = '0;
    logic [TimeW-1:0] abs_start_q = '0;
    logic [StepW-1:0] run_start = '0;
    logic [StepW-1:0] run_end = '0;
    logic [BatW-1:0]  run_setpoint = '0;
    logic             run_fixed = 1'b0;

    battery_cycle_test_sequencer dut (.*);

    always #2 clk = ~clk;

    // Advance the mirrored sequencer by one poll and return the result it should show.
    task automatic advance_sequencer(input logic req, input logic [TimeW-1:0] t,
                                     input logic [BatW-1:0] bat, input logic [SolW-1:0] sol,
                                     output step_result_t res);
        event_t           ev;
        logic [TimeW-1:0] elapsed;
        ev = EV_NONE;
        if (req)
        begin
            run_fixed = mode_reg;
            run_start = start_reg;
            run_end = mode_reg ? start_reg : end_reg;
            run_setpoint = disch_reg;
            load_q = start_reg;
            steady_q = mode_reg;
            absorbing_q = 1'b0;
            if (mode_reg)
                shut_q = 1'b1;
            report_start_q = t;
            phase_q = PH_CHECK;
            ev = EV_REPORT;
        end
        else
        begin
            case (phase_q)
                PH_CHECK:
                begin
                    if (absorbing_q)
                        phase_q = PH_ABSORB;
                    else if ({1'b0, load_q} + 5'd1 > {1'b0, run_end})
                    begin
                        // Top step: discharge ends under the setpoint, else track report levels.
                        if (bat < run_setpoint && bat > BatteryFloorMv)
                        begin
                            load_q = run_start;
                            steady_q = 1'b1;
                            shut_q = 1'b0;
                            phase_q = PH_MPPT;
                        end
                        else if (bat < level_q && bat > BatteryFloorMv)
                        begin
                            phase_q = PH_DELAY;
                            level_q = (level_q >= ReportStepMv) ? level_q - ReportStepMv : '0;
                        end
                    end
                    else if (run_fixed)
                        phase_q = PH_DELAY;
                    else if (sol > SolarDayMv)
                    begin
                        if (load_q == run_start && !shut_q && !steady_q)
                        begin
                            shut_q = 1'b1;
                            level_q = FirstReportMv;
                        end
                        else if (!steady_q)
                        begin
                            load_q = load_q + 4'd1;
                            phase_q = PH_DELAY;
                        end
                        else
                        begin
                            abs_start_q = t;
                            absorbing_q = 1'b1;
                            phase_q = PH_ABSORB;
                            ev = EV_ABS_BEG;
                        end
                    end
                end
                PH_MPPT:
                begin
                    if (run_fixed)
                        phase_q = PH_DELAY;
                    else if (sol > MpptLowMv && sol < MpptHighMv)
                    begin
                        phase_q = PH_DELAY;
                        ev = EV_MPPT;
                    end
                end
                PH_DELAY:
                begin
                    elapsed = t - report_start_q;
                    if (elapsed > ReportPeriodMs)
                    begin
                        report_start_q = t;
                        phase_q = PH_CHECK;
                        ev = EV_REPORT;
                    end
                end
                PH_ABSORB:
                begin
                    elapsed = t - abs_start_q;
                    if (elapsed > AbsorbPeriodMs)
                    begin
                        absorbing_q = 1'b0;
                        phase_q = PH_NIGHT;
                        ev = EV_ABS_END;
                    end
                end
                PH_NIGHT:
                begin
                    if (run_fixed)
                        phase_q = PH_DELAY;
                    else if (sol > '0 && sol < NightHighMv)
                    begin
                        load_q = run_end;
                        shut_q = 1'b1;
                        level_q = FirstReportMv;
                        phase_q = PH_DELAY;
                        ev = EV_NIGHT;
                    end
                end
                default:
                    phase_q = PH_IDLE;
            endcase
        end
        res = '{load_q, shut_q, ev};
    endtask

    function automatic dir_row_t poll_row(logic req, logic [TimeW-1:0] t,
                                          logic [BatW-1:0] b, logic [SolW-1:0] s);
        dir_row_t r;
        r = '0;
        r.kind = ROW_POLL;
        r.req = req;
        r.now = t;
        r.bat = b;
        r.sol = s;
        return r;
    endfunction

    function automatic dir_row_t typed_row(logic req, logic [TimeW-1:0] t,
                                           logic [BatW-1:0] b, logic [SolW-1:0] s,
                                           logic [StepW-1:0] load, logic shut, event_t ev);
        dir_row_t r;
        r = poll_row(req, t, b, s);
        r.typed = 1'b1;
        r.want = '{load, shut, ev};
        return r;
    endfunction

    function automatic dir_row_t cfg_row(logic [StepW-1:0] s, logic [StepW-1:0] e,
                                         logic [BatW-1:0] d, logic m);
        dir_row_t r;
        r = '0;
        r.kind = ROW_CFG;
        r.c_start = s;
        r.c_end = e;
        r.c_disch = d;
        r.c_mode = m;
        return r;
    endfunction

    // Offer one poll request, wait for it to be taken and queue its expected result.
    task automatic send_poll(input dir_row_t r);
        step_result_t got;
        if (!calm && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
        in_valid   <= 1'b1;
        start_req  <= r.req;
        now_ms     <= r.now;
        battery_mv <= r.bat;
        solar_mv   <= r.sol;
        do @(posedge clk); while (in_stall);
        advance_sequencer(r.req, r.now, r.bat, r.sol, got);
        pending_results.push_back(r.typed ? r.want : got);
    endtask

    // Stop polling and let every outstanding result drain.
    task automatic settle_idle();
        in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    // Write all four registers back to back; the block must be idle.
    task automatic load_registers(input logic [StepW-1:0] s, input logic [StepW-1:0] e,
                                  input logic [BatW-1:0] d, input logic m);
        cfg_reg_t            idx;
        logic [CfgDataW-1:0] val;
        for (int k = 0; k < 4; k++)
        begin
            idx = cfg_reg_t'(k);
            val = '0;
            case (idx)
                REG_START_STEP:   val = CfgDataW'(s);
                REG_END_STEP:     val = CfgDataW'(e);
                REG_DISCHARGE_MV: val = d;
                REG_RUN_MODE:     val = CfgDataW'(m);
                default:          val = '0;
            endcase
            cfg_valid <= 1'b1;
            cfg_index <= idx;
            cfg_data  <= val;
            do @(posedge clk); while (!cfg_ready);
        end
        cfg_valid <= 1'b0;
        start_reg = s;
        end_reg = e;
        disch_reg = d;
        mode_reg = m;
    endtask

    // Stimulus: directed table first, then steered random polls.
    initial
    begin
        dir_row_t         dir_rows[$];
        dir_row_t         r;
        logic [TimeW-1:0] clock_ms;
        logic [BatW-1:0]  anchor;
        logic [SolW-1:0]  sol_pick;
        logic [StepW-1:0] s_pick;
        logic [StepW-1:0] e_pick;
        logic [BatW-1:0]  d_pick;
        int               bat_i;

        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_valid = 1'b0;
        start_req = 1'b0;
        now_ms = '0;
        battery_mv = '0;
        solar_mv = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Idle polls before any run, fields at their floor and then their ceiling.
        dir_rows.push_back(typed_row(1'b0, 32'h0000_0000, 13'd0, 15'd0, 4'd0, 1'b0, EV_NONE));
        dir_rows.push_back(typed_row(1'b0, 32'hFFFF_FFFF, 13'd7500, 15'd26600,
                                     4'd0, 1'b0, EV_NONE));
        // Two-step sweep that starts just before the millisecond counter wraps.
        dir_rows.push_back(cfg_row(4'd0, 4'd1, 13'd6200, 1'b0));
        dir_rows.push_back(typed_row(1'b1, 32'hFFFF_FC00, 13'd7000, 15'd20000,
                                     4'd0, 1'b0, EV_REPORT));
        dir_rows.push_back(poll_row(1'b0, 32'hFFFF_FC0A, 13'd7000, 15'd20000));
        dir_rows.push_back(poll_row(1'b0, 32'hFFFF_FC14, 13'd7000, 15'd20000));
        // Exactly one report period is not enough; one more millisecond is.
        dir_rows.push_back(poll_row(1'b0, 32'h0000_03D0, 13'd7000, 15'd20000));
        dir_rows.push_back(poll_row(1'b0, 32'h0000_03D1, 13'd7000, 15'd20000));
        // Top step: battery crosses a report level, then falls under the setpoint.
        dir_rows.push_back(poll_row(1'b0, 32'h0000_03D2, 13'd6300, 15'd0));
        dir_rows.push_back(poll_row(1'b0, 32'h0000_0BA2, 13'd6300, 15'd0));
        dir_rows.push_back(poll_row(1'b0, 32'h0000_0BA3, 13'd6100, 15'd0));
        dir_rows.push_back(poll_row(1'b0, 32'h0000_0BA4, 13'd6100, 15'd16500));
        dir_rows.push_back(poll_row(1'b0, 32'h0000_1373, 13'd6100, 15'd16500));
        // Absorption over exactly its period and one millisecond past it.
        dir_rows.push_back(poll_row(1'b0, 32'h0000_1374, 13'd6100, 15'd20000));
        dir_rows.push_back(poll_row(1'b0, 32'd10804980, 13'd6100, 15'd20000));
        dir_rows.push_back(poll_row(1'b0, 32'd10804981, 13'd6100, 15'd20000));
        // Night needs a nonzero solar reading under the night threshold.
        dir_rows.push_back(poll_row(1'b0, 32'd10804982, 13'd6100, 15'd0));
        dir_rows.push_back(poll_row(1'b0, 32'd10804983, 13'd6100, 15'd4999));
        // Fixed run at the top step with an out-of-range setpoint and the battery floor.
        dir_rows.push_back(cfg_row(4'd15, 4'd15, 13'd8191, 1'b1));
        dir_rows.push_back(typed_row(1'b1, 32'd20000000, 13'd7500, 15'd26600,
                                     4'd15, 1'b1, EV_REPORT));
        dir_rows.push_back(poll_row(1'b0, 32'd20000001, 13'd4000, 15'd26600));
        dir_rows.push_back(poll_row(1'b0, 32'd20000002, 13'd4001, 15'd26600));
        dir_rows.push_back(poll_row(1'b0, 32'd20000003, 13'd4001, 15'd16500));
        // Start step above end step goes straight to the top-step checks.
        dir_rows.push_back(cfg_row(4'd9, 4'd3, 13'd6000, 1'b0));
        dir_rows.push_back(typed_row(1'b1, 32'd20000004, 13'd6540, 15'd20000,
                                     4'd9, 1'b0, EV_REPORT));
        dir_rows.push_back(poll_row(1'b0, 32'd20000005, 13'd6540, 15'd20000));

        foreach (dir_rows[i])
        begin
            if (dir_rows[i].kind == ROW_CFG)
            begin
                settle_idle();
                load_registers(dir_rows[i].c_start, dir_rows[i].c_end,
                               dir_rows[i].c_disch, dir_rows[i].c_mode);
            end
            else
                send_poll(dir_rows[i]);
        end

        clock_ms = $urandom;
        for (int n = 0; n < RandPolls; n++)
        begin
            calm = (n >= RandPolls - CalmPolls);

            // Periodically pick a new run setup, favoring the extremes.
            if (n % RegPeriod == RegPeriod - 1)
            begin
                case ($urandom_range(0, 3))
                    0:       s_pick = '0;
                    1:       s_pick = '1;
                    default: s_pick = StepW'($urandom_range(0, 15));
                endcase
                if ($urandom_range(0, 4) == 0)
                    e_pick = StepW'($urandom_range(0, 15));
                else if (s_pick > 4'd11)
                    e_pick = 4'd15;
                else
                    e_pick = s_pick + StepW'($urandom_range(0, 4));
                case ($urandom_range(0, 7))
                    0:       d_pick = 13'd6000;
                    1:       d_pick = 13'd6500;
                    2:       d_pick = BatW'($urandom_range(0, 8191));
                    default: d_pick = BatW'($urandom_range(6000, 6500));
                endcase
                settle_idle();
                load_registers(s_pick, e_pick, d_pick, $urandom_range(0, 3) == 0);
            end

            if ($urandom_range(0, 9) == 0)
            begin
                // Noise: every field anywhere in its range.
                clock_ms = $urandom;
                r = poll_row($urandom_range(0, 7) == 0, clock_ms,
                             BatW'($urandom_range(0, 7500)), SolW'($urandom_range(0, 26600)));
            end
            else
            begin
                // Time lands on the period boundaries often enough to move the run along.
                if (phase_q == PH_ABSORB && $urandom_range(0, 1) == 0)
                    clock_ms = abs_start_q + AbsorbPeriodMs + $urandom_range(0, 2) - 1;
                else if ($urandom_range(0, 2) == 0)
                    clock_ms = report_start_q + ReportPeriodMs + $urandom_range(0, 2) - 1;
                else
                    clock_ms = clock_ms + $urandom_range(0, 900);

                // Solar readings suited to what the current phase waits for.
                sol_pick = SolW'($urandom_range(0, 26600));
                case (phase_q)
                    PH_CHECK:
                        if ($urandom_range(0, 3) != 0)
                            sol_pick = SolW'($urandom_range(17999, 26600));
                    PH_MPPT:
                        if ($urandom_range(0, 1) == 0)
                            sol_pick = SolW'($urandom_range(15999, 17001));
                    PH_NIGHT:
                        if ($urandom_range(0, 1) == 0)
                            sol_pick = SolW'($urandom_range(0, 5001));
                    default:
                        ;
                endcase

                // Battery readings cluster around the thresholds that matter.
                case ($urandom_range(0, 3))
                    0:       anchor = level_q;
                    1:       anchor = run_setpoint;
                    2:       anchor = BatteryFloorMv;
                    default: anchor = BatW'($urandom_range(0, 7500));
                endcase
                bat_i = int'(anchor) + int'($urandom_range(0, 40)) - 20;
                if (bat_i < 0)
                    bat_i = 0;
                if (bat_i > 7500)
                    bat_i = 7500;

                r = poll_row(phase_q == PH_IDLE || $urandom_range(0, 59) == 0, clock_ms,
                             BatW'(bat_i), sol_pick);
            end
            send_poll(r);
        end

        settle_idle();
        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // Result side backpressure in random bursts, none in the closing stretch.
    initial
    begin
        int hold;
        hold = 0;
        out_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold > 0 && !calm)
            begin
                out_stall <= 1'b1;
                hold--;
            end
            else
            begin
                out_stall <= 1'b0;
                if (!calm && $urandom_range(0, 7) == 0)
                    hold = $urandom_range(1, 8);
            end
        end
    end

    // Compare each delivered result with the oldest expectation.
    always @(posedge clk)
    begin : result_check
        step_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result with nothing expected: load_level %0d charger_off %0d %s %0d",
                       load_level, charger_off, "event_res", event_res);
                fail_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (load_level !== want.load)
                begin
                    $error("load_level expected %0d got %0d", want.load, load_level);
                    fail_count++;
                end
                if (charger_off !== want.shut)
                begin
                    $error("charger_off expected %0d got %0d", want.shut, charger_off);
                    fail_count++;
                end
                if (event_res !== want.ev)
                begin
                    $error("event_res expected %0d got %0d", want.ev, event_res);
                    fail_count++;
                end
            end
        end
    end

    // Hang guard.
    initial
    begin
        #2000000;
        $display("FAIL");
        $finish;
    end

endmodule

`default_nettype wire
